[sv/comment_whitespace_stripper_macros.svh]
// ----------------------------------------------------------------------------
// Comment and whitespace stripper assertion macros
// Checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMMENT_WHITESPACE_STRIPPER_MACROS_SVH
`define COMMENT_WHITESPACE_STRIPPER_MACROS_SVH

// same-cycle implication
`define CWS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cws assertion failed");

// next-cycle implication
`define CWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cws assertion failed");

`endif

[sv/cws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comment and whitespace stripper package
// Character codes, result types and the per-byte classification function.
// ----------------------------------------------------------------------------
package cws_pkg;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_BLOCK = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } res_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       in_string;
    logic [1:0] kind;
    logic       keep;
  } judge_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic judge_t judge(input logic       in_string,
                                   input logic [1:0] kind,
                                   input logic [7:0] bef,
                                   input logic       bef_v,
                                   input logic [7:0] c,
                                   input logic [7:0] look);
    judge_t     r;
    logic       prev_bs;
    logic       prev_star;
    logic [1:0] entry;
    prev_bs     = bef_v && (bef == CH_BSLASH);
    prev_star   = bef_v && (bef == CH_STAR);
    entry       = kind;
    r.in_string = in_string;
    r.kind      = kind;
    r.keep      = 1'b0;
    if (kind == KIND_NONE && (c == CH_DQUOTE || c == CH_SQUOTE) && !prev_bs) begin
      r.in_string = !in_string;
    end
    if (r.in_string) begin
      r.keep = 1'b1;
    end else begin
      if (kind == KIND_NONE && c == CH_SLASH) begin
        if (look == CH_SLASH) begin
          r.kind = KIND_LINE;
        end else if (look == CH_STAR) begin
          r.kind = KIND_BLOCK;
        end
      end
      r.keep = (r.kind == KIND_NONE) && !is_ws(c);
      if (entry == KIND_LINE && (c == CH_LF || c == CH_CR)) begin
        r.kind = KIND_NONE;
      end else if (entry == KIND_BLOCK && prev_star && c == CH_SLASH) begin
        r.kind = KIND_NONE;
      end
    end
    return r;
  endfunction

endpackage

[sv/cws_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one raw text byte and its end flag.
// ----------------------------------------------------------------------------
interface cws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

[sv/cws_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one kept byte or an end marker.
// ----------------------------------------------------------------------------
interface cws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output byte_valid,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input run_last, input text_end, output ready);
endinterface

[sv/cws_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stripper front end
// Accepts bytes, tracks string and comment state, pushes result groups.
// ----------------------------------------------------------------------------
module cws_front (
  input  logic              clk,
  input  logic              rst_n,
  cws_in_if.sink            in_chan,
  input  cws_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output cws_pkg::group_t   q_group
);
  import cws_pkg::*;

  logic [7:0] held_byte_r,    held_byte_nxt;
  logic       held_valid_r,   held_valid_nxt;
  logic [7:0] before_byte_r,  before_byte_nxt;
  logic       before_valid_r, before_valid_nxt;
  logic       in_string_r,    in_string_nxt;
  logic [1:0] kind_r,         kind_nxt;

  logic       in_acc;
  judge_t     j0;
  judge_t     j1;
  logic       keep0;
  logic       str1;
  logic [1:0] kind1;
  logic [7:0] bef1;
  logic       bv1;
  res_t       res_held;
  res_t       res_last;

  assign in_chan.ready = !q_stat.full;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign j0    = judge(in_string_r, kind_r, before_byte_r, before_valid_r,
                       held_byte_r, in_chan.in_byte);
  assign keep0 = held_valid_r && j0.keep;
  assign str1  = held_valid_r ? j0.in_string : in_string_r;
  assign kind1 = held_valid_r ? j0.kind : kind_r;
  assign bef1  = held_valid_r ? held_byte_r : before_byte_r;
  assign bv1   = held_valid_r || before_valid_r;
  assign j1    = judge(str1, kind1, bef1, bv1, in_chan.in_byte, CH_NUL);

  assign res_held = '{out_byte: held_byte_r, byte_valid: 1'b1,
                      run_last: 1'b1, text_end: 1'b0};
  assign res_last = '{out_byte: in_chan.in_byte, byte_valid: 1'b1,
                      run_last: 1'b1, text_end: 1'b1};

  always_comb begin
    q_group    = '0;
    q_push     = 1'b0;
    if (!in_chan.text_last) begin
      q_push   = in_acc && keep0;
      q_group.r0 = res_held;
    end else begin
      q_push = in_acc;
      case ({keep0, j1.keep})
        2'b11: begin
          q_group.r0          = res_held;
          q_group.r0.run_last = 1'b0;
          q_group.r1          = res_last;
          q_group.two         = 1'b1;
        end
        2'b10: begin
          q_group.r0          = res_held;
          q_group.r0.text_end = 1'b1;
        end
        2'b01: begin
          q_group.r0 = res_last;
        end
        default: begin
          q_group.r0 = '{out_byte: CH_NUL, byte_valid: 1'b0,
                         run_last: 1'b1, text_end: 1'b1};
        end
      endcase
    end
  end

  always_comb begin
    held_byte_nxt    = held_byte_r;
    held_valid_nxt   = held_valid_r;
    before_byte_nxt  = before_byte_r;
    before_valid_nxt = before_valid_r;
    in_string_nxt    = in_string_r;
    kind_nxt         = kind_r;
    if (in_acc) begin
      if (in_chan.text_last) begin
        held_byte_nxt    = '0;
        held_valid_nxt   = 1'b0;
        before_byte_nxt  = '0;
        before_valid_nxt = 1'b0;
        in_string_nxt    = 1'b0;
        kind_nxt         = KIND_NONE;
      end else begin
        held_byte_nxt    = in_chan.in_byte;
        held_valid_nxt   = 1'b1;
        before_byte_nxt  = bef1;
        before_valid_nxt = bv1;
        in_string_nxt    = str1;
        kind_nxt         = kind1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r    <= '0;
      held_valid_r   <= 1'b0;
      before_byte_r  <= '0;
      before_valid_r <= 1'b0;
      in_string_r    <= 1'b0;
      kind_r         <= KIND_NONE;
    end else begin
      held_byte_r    <= held_byte_nxt;
      held_valid_r   <= held_valid_nxt;
      before_byte_r  <= before_byte_nxt;
      before_valid_r <= before_valid_nxt;
      in_string_r    <= in_string_nxt;
      kind_r         <= kind_nxt;
    end
  end

endmodule

[sv/cws_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stripper result queue
// Short queue of result groups between the front and back ends.
// ----------------------------------------------------------------------------
module cws_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cws_pkg::group_t   push_group,
  input  logic              pop,
  output cws_pkg::group_t   head_group,
  output cws_pkg::q_stat_t  stat
);
  import cws_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  group_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r,    cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_group = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/cws_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stripper back end
// Splits queued result groups into single results behind an output register.
// ----------------------------------------------------------------------------
module cws_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cws_pkg::group_t   head_group,
  input  cws_pkg::q_stat_t  q_stat,
  output logic              q_pop,
  cws_out_if.source         out_chan
);
  import cws_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r,   out_res_nxt;
  logic idx_r,       idx_nxt;
  logic load;
  logic head_valid;
  logic group_done;

  assign head_valid = !q_stat.empty;
  assign load       = !out_valid_r || out_chan.ready;
  assign group_done = idx_r || !head_group.two;
  assign q_pop      = load && head_valid && group_done;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_res_nxt = idx_r ? head_group.r1 : head_group.r0;
        idx_nxt     = !group_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_byte   = out_res_r.out_byte;
  assign out_chan.byte_valid = out_res_r.byte_valid;
  assign out_chan.run_last   = out_res_r.run_last;
  assign out_chan.text_end   = out_res_r.text_end;

endmodule

[sv/comment_whitespace_stripper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comment and whitespace stripper
// Passes string contents and significant bytes; drops whitespace and comments.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one text byte per request plus text_last on the final one.
//   out_chan carries kept bytes; a text with nothing kept ends in one marker
//   request with byte_valid low. text_end marks the final request of a text.
//   One byte is held back as lookahead, so a byte's result is produced when
//   the byte after it is accepted; the final byte flushes both.
//   The front logic pushes a request's results into the queue as one group
//   when the request is accepted; the back end then moves each result into
//   the output register whenever that register is empty or being taken.
//   Throughput: one byte per cycle while the queue is not full; a final byte
//   that yields two results is one group in the queue (QUEUE_DEPTH groups).
//   Reset clears string/comment state, the held byte and the queue.
//   When out_chan stalls, the output register holds and the queue fills;
//   in_chan.ready drops only once the queue is full.
// ----------------------------------------------------------------------------
`include "comment_whitespace_stripper_macros.svh"

module comment_whitespace_stripper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  cws_in_if.sink     in_chan,
  cws_out_if.source  out_chan
);
  import cws_pkg::*;

  logic    q_push;
  logic    q_pop;
  group_t  q_group;
  group_t  head_group;
  q_stat_t q_stat;

  cws_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_group (q_group)
  );

  cws_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_group (q_group),
    .pop        (q_pop),
    .head_group (head_group),
    .stat       (q_stat)
  );

  cws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_group (head_group),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_chan   (out_chan)
  );

  `CWS_ASSERT_SAME(a_no_overflow, q_push, !q_stat.full)
  `CWS_ASSERT_NEXT(a_last_queued, in_chan.valid && in_chan.ready && in_chan.text_last, !q_stat.empty)
  `CWS_ASSERT_SAME(a_marker_ends, out_chan.valid && !out_chan.byte_valid, out_chan.text_end && out_chan.run_last)
  `CWS_ASSERT_SAME(a_end_is_last, out_chan.valid && out_chan.text_end, out_chan.run_last)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comment and whitespace stripper testbench
// Sends short texts, first hand-picked cases and then random ones, as byte
// requests with random gaps on the input side. The result side also stalls at
// random. A local model of the stripper predicts every kept byte and every end
// marker, and the monitor checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import cws_pkg::*;

  localparam int RANDOM_REQS = 1850;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         drain;
  } byte_req_t;

  logic clk = 1'b0;
  logic rst_n;

  cws_in_if  in_if();
  cws_out_if out_if();

  comment_whitespace_stripper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_req_t  pending [$];
  logic [7:0] text_buf [$];
  res_t       stripped_q [$];
  int         total_reqs = 0;
  int         sent_reqs = 0;
  int         mismatches = 0;
  int         idle_run = 0;

  // model state
  logic [7:0] hold_b;
  logic       hold_v;
  logic [7:0] prior_b;
  logic       prior_v;
  logic       quoted;
  logic [1:0] cmt;

  function automatic logic blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic byte_kept(input logic [7:0] c, input logic [7:0] look);
    logic       esc;
    logic       star_before;
    logic       keep;
    logic [1:0] was;
    esc         = prior_v && (prior_b == CH_BSLASH);
    star_before = prior_v && (prior_b == CH_STAR);
    if (cmt == KIND_NONE && (c == CH_DQUOTE || c == CH_SQUOTE) && !esc) begin
      quoted = !quoted;
    end
    if (quoted) begin
      return 1'b1;
    end
    was = cmt;
    if (cmt == KIND_NONE && c == CH_SLASH) begin
      if (look == CH_SLASH) begin
        cmt = KIND_LINE;
      end else if (look == CH_STAR) begin
        cmt = KIND_BLOCK;
      end
    end
    keep = (cmt == KIND_NONE) && !blank(c);
    if (was == KIND_LINE && (c == CH_LF || c == CH_CR)) begin
      cmt = KIND_NONE;
    end else if (was == KIND_BLOCK && star_before && c == CH_SLASH) begin
      cmt = KIND_NONE;
    end
    return keep;
  endfunction

  task automatic clear_model();
    hold_b  = CH_NUL;
    hold_v  = 1'b0;
    prior_b = CH_NUL;
    prior_v = 1'b0;
    quoted  = 1'b0;
    cmt     = KIND_NONE;
  endtask

  task automatic strip_step(input logic [7:0] b, input logic last);
    res_t run [$];
    res_t r;
    if (hold_v) begin
      if (byte_kept(hold_b, b)) begin
        r = '{out_byte: hold_b, byte_valid: 1'b1, run_last: 1'b0, text_end: 1'b0};
        run = {run, r};
      end
      prior_b = hold_b;
      prior_v = 1'b1;
    end
    if (!last) begin
      hold_b = b;
      hold_v = 1'b1;
    end else begin
      if (byte_kept(b, CH_NUL)) begin
        r = '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, text_end: 1'b0};
        run = {run, r};
      end
      if (run.size() == 0) begin
        r = '{out_byte: CH_NUL, byte_valid: 1'b0, run_last: 1'b0, text_end: 1'b0};
        run = {run, r};
      end
      run[run.size() - 1].text_end = 1'b1;
      clear_model();
    end
    if (run.size() != 0) begin
      run[run.size() - 1].run_last = 1'b1;
    end
    foreach (run[i]) stripped_q = {stripped_q, run[i]};
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) begin
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  // stimulus construction
  task automatic put_byte(input logic [7:0] c);
    text_buf = {text_buf, c};
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic queue_text(input bit drain);
    byte_req_t req;
    foreach (text_buf[i]) begin
      req.b     = text_buf[i];
      req.last  = (i == text_buf.size() - 1);
      req.drain = drain && (i == 0);
      pending = {pending, req};
      total_reqs++;
    end
    text_buf.delete();
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 8))
          0: return CH_DQUOTE;
          1: return CH_SQUOTE;
          2: return CH_BSLASH;
          3: return CH_SLASH;
          4: return CH_STAR;
          5: return CH_LF;
          6: return CH_CR;
          7: return CH_SPACE;
          default: return CH_TAB;
        endcase
      end
      4, 5, 6: return CH_LOWER_A + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_chars(input int n);
    for (int i = 0; i < n; i++) put_byte(rand_char());
  endtask

  task automatic build_text();
    logic [7:0] q;
    int         tokens;
    if ($urandom_range(0, 9) < 3) begin
      add_chars($urandom_range(1, 12));
      return;
    end
    tokens = $urandom_range(1, 8);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(0, 5))
        0: for (int i = $urandom_range(1, 4); i > 0; i--)
             put_byte(CH_LOWER_A + 8'($urandom_range(0, 25)));
        1: for (int i = $urandom_range(1, 3); i > 0; i--)
             put_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
        2: begin
          put_byte(CH_SLASH);
          put_byte(CH_SLASH);
          add_chars($urandom_range(0, 4));
          put_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
        end
        3: begin
          put_byte(CH_SLASH);
          put_byte(CH_STAR);
          add_chars($urandom_range(0, 4));
          put_byte(CH_STAR);
          put_byte(CH_SLASH);
        end
        4: begin
          q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          put_byte(q);
          for (int i = $urandom_range(0, 4); i > 0; i--) begin
            if ($urandom_range(0, 4) == 0) begin
              put_byte(CH_BSLASH);
              put_byte(q);
            end else begin
              put_byte(rand_char());
            end
          end
          put_byte(q);
        end
        default: add_chars($urandom_range(1, 3));
      endcase
    end
  endtask

  // driver
  int        gap_left = 0;
  bit        in_burst = 1'b0;
  logic      in_go;
  byte_req_t cur_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.in_byte   <= CH_NUL;
      in_if.text_last <= 1'b0;
      gap_left = 0;
    end else begin
      in_go = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        strip_step(in_if.in_byte, in_if.text_last);
        sent_reqs++;
        in_go = 1'b0;
        gap_left = in_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      end
      if (!in_go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && stripped_q.size() != 0)) begin
          cur_req = pending.pop_front();
          in_if.in_byte   <= cur_req.b;
          in_if.text_last <= cur_req.last;
          in_go = 1'b1;
        end
      end
      in_if.valid <= in_go;
    end
  end

  // monitor
  int   stall_left = 0;
  bit   out_burst = 1'b0;
  logic out_go;
  res_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      out_go = out_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (stripped_q.size() == 0) begin
          report_mismatch("unexpected result", out_if.out_byte, 0);
        end else begin
          want = stripped_q.pop_front();
          if (out_if.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_if.out_byte, want.out_byte);
          if (out_if.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", out_if.byte_valid, want.byte_valid);
          if (out_if.run_last !== want.run_last)
            report_mismatch("run_last", out_if.run_last, want.run_last);
          if (out_if.text_end !== want.text_end)
            report_mismatch("text_end", out_if.text_end, want.text_end);
        end
        stall_left = out_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_go = (stall_left == 0);
      end else if (!out_go) begin
        if (stall_left > 0) stall_left--;
        out_go = (stall_left == 0);
      end
      out_if.ready <= out_go;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int directed;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.in_byte   = CH_NUL;
    in_if.text_last = 1'b0;
    out_if.ready    = 1'b0;
    clear_model();

    // whitespace only, single byte, quote in line comment
    push_str(" \t");
    queue_text(1'b0);
    text_buf = '{8'hFF};
    queue_text(1'b0);
    push_str("a//'\rb");
    queue_text(1'b0);
    // star before opening slash, slash right after opening star, open string
    push_str("*/*/\"\\\"");
    queue_text(1'b0);
    text_buf = '{CH_NUL, 8'h80, 8'h7F};
    queue_text(1'b1);
    push_str("'/ '");
    queue_text(1'b0);
    push_str("/**/x");
    queue_text(1'b0);

    directed = total_reqs;
    while (total_reqs < directed + RANDOM_REQS) begin
      build_text();
      queue_text($urandom_range(0, 29) == 0);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        wait (sent_reqs == total_reqs);
        while (stripped_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      begin
        while (idle_run < IDLE_LIMIT) @(posedge clk);
      end
    join_any

    if (idle_run >= IDLE_LIMIT) begin
      $display("status: fail");
    end else begin
      if (stripped_q.size() != 0) begin
        report_mismatch("results missing", 0, stripped_q.size());
      end
      if (mismatches == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule

[comment_whitespace_stripper.f]
+incdir+sv
sv/cws_pkg.sv
sv/cws_in_if.sv
sv/cws_out_if.sv
sv/cws_front.sv
sv/cws_fifo.sv
sv/cws_back.sv
sv/comment_whitespace_stripper.sv
tb/testbench.sv
